@@ rtl/core/i2cm_pkg.sv @@
// Shared types and constants for the I2C register master.
`timescale 1ns / 1ps
`default_nettype none

package i2cm_pkg;

    localparam int MAX_LEN  = 16;
    localparam int BUF_AW   = $clog2(MAX_LEN);
    localparam int LEN_W    = 5;
    localparam int CFG_DW   = 8;

    // Command codes
    localparam logic [1:0] CMD_TICK  = 2'd0;
    localparam logic [1:0] CMD_LOAD  = 2'd1;
    localparam logic [1:0] CMD_WRITE = 2'd2;
    localparam logic [1:0] CMD_READ  = 2'd3;

    // Configuration register indexes
    localparam logic REG_DEV_ADDR    = 1'b0;
    localparam logic REG_ACK_TIMEOUT = 1'b1;

    localparam logic [6:0] DEV_ADDR_RST    = 7'd80;
    localparam logic [7:0] ACK_TIMEOUT_RST = 8'd50;

    typedef enum logic [16:0] {
        PH_IDLE     = 17'h00001,
        PH_ST_A     = 17'h00002,
        PH_ST_B     = 17'h00004,
        PH_ST_C     = 17'h00008,
        PH_TX_LO    = 17'h00010,
        PH_TX_HI    = 17'h00020,
        PH_ACK_REL  = 17'h00040,
        PH_ACK_POLL = 17'h00080,
        PH_ACK_CLK  = 17'h00100,
        PH_RS_GAP   = 17'h00200,
        PH_RX_LO    = 17'h00400,
        PH_RX_HI    = 17'h00800,
        PH_MA_LO    = 17'h01000,
        PH_MA_HI    = 17'h02000,
        PH_SP_A     = 17'h04000,
        PH_SP_B     = 17'h08000,
        PH_SP_C     = 17'h10000
    } t_phase;

    typedef enum logic [3:0] {
        STG_ADDR_W = 4'b0001,
        STG_REG    = 4'b0010,
        STG_DATA   = 4'b0100,
        STG_ADDR_R = 4'b1000
    } t_stage;

endpackage

`default_nettype wire

@@ rtl/core/i2c_register_master_top.sv @@
// I2C register master: one bus phase per accepted item, registered result.
// The result of an item is captured in the output register at acceptance and shows in the cycle after.
// Throughput: one item per cycle while the output is not stalled; the phase controller updates its state registers once
// per accepted item and the output register decouples the result side.
// Reset (synchronous, active low) returns the controller to idle, clears counters and
// restores the register defaults; write buffer contents are left as they are.
`timescale 1ns / 1ps
`default_nettype none

module i2c_register_master_top (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    // configuration
    input  wire logic        i_cfg_we,
    input  wire logic        i_cfg_index,
    input  wire logic [i2cm_pkg::CFG_DW-1:0] i_cfg_data,
    // input channel
    input  wire logic        i_in_valid,
    output logic             o_in_stall,
    input  wire logic [1:0]  i_command,
    input  wire logic [7:0]  i_register_address,
    input  wire logic [7:0]  i_data_byte,
    input  wire logic [4:0]  i_length,
    input  wire logic        i_sda_in,
    // output channel
    output logic             o_out_valid,
    input  wire logic        i_out_stall,
    output logic             o_scl_level,
    output logic             o_sda_drive,
    output logic             o_busy_res,
    output logic [7:0]       o_rx_byte,
    output logic             o_read_valid,
    output logic             o_read_last,
    output logic             o_done_res,
    output logic             o_status
);

    localparam int LW = i2cm_pkg::LEN_W;

    logic                  accept;

    logic [6:0]            r_dev_addr;
    logic [7:0]            r_ack_timeout;

    i2cm_pkg::t_phase      r_phase, n_phase;
    i2cm_pkg::t_stage      r_stage, n_stage;
    logic [3:0]            r_bit_cnt, n_bit_cnt;
    logic [LW-1:0]         r_byte_cnt, n_byte_cnt;
    logic [7:0]            r_shift, n_shift;
    logic [7:0]            r_ack_cnt, n_ack_cnt;
    logic [LW-1:0]         r_fill, n_fill;
    logic                  r_read_mode, n_read_mode;
    logic [LW-1:0]         r_xfer_len, n_xfer_len;
    logic [7:0]            r_target_reg, n_target_reg;
    logic                  r_failed, n_failed;
    logic [7:0]            r_wbuf [i2cm_pkg::MAX_LEN];

    logic                  buf_we;

    logic                  n_scl, n_sda, n_rvalid, n_rlast, n_done, n_stat;
    logic [7:0]            n_rbyte;

    logic [LW-1:0]         sat_len;
    logic [LW-1:0]         nd_cnt;
    logic                  nd_avail;
    logic [3:0]            bit_inc;
    logic [LW:0]           byte_inc;
    logic                  last_byte;
    logic [7:0]            ack_dec;

    assign o_in_stall = o_out_valid && i_out_stall;
    assign accept     = i_in_valid && !o_in_stall;

    // configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dev_addr    <= i2cm_pkg::DEV_ADDR_RST;
            r_ack_timeout <= i2cm_pkg::ACK_TIMEOUT_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                i2cm_pkg::REG_DEV_ADDR:    r_dev_addr    <= i_cfg_data[6:0];
                i2cm_pkg::REG_ACK_TIMEOUT: r_ack_timeout <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // helpers for the phase logic
    assign bit_inc   = r_bit_cnt + 4'd1;
    assign byte_inc  = {1'b0, r_byte_cnt} + {{LW{1'b0}}, 1'b1};
    assign last_byte = (byte_inc >= {1'b0, r_xfer_len});
    assign ack_dec   = (r_ack_cnt != 8'd0) ? (r_ack_cnt - 8'd1) : r_ack_cnt;
    assign nd_cnt    = (r_stage == i2cm_pkg::STG_DATA) ? byte_inc[LW-1:0] : r_byte_cnt;
    assign nd_avail  = (nd_cnt < r_xfer_len) && (nd_cnt < LW'(i2cm_pkg::MAX_LEN));

    always_comb begin
        sat_len = (i_length > LW'(i2cm_pkg::MAX_LEN)) ? LW'(i2cm_pkg::MAX_LEN) : i_length;
        if (i_command == i2cm_pkg::CMD_READ && sat_len == '0) begin
            sat_len = LW'(1);
        end
    end

    always_comb begin
        n_phase      = r_phase;
        n_stage      = r_stage;
        n_bit_cnt    = r_bit_cnt;
        n_byte_cnt   = r_byte_cnt;
        n_shift      = r_shift;
        n_ack_cnt    = r_ack_cnt;
        n_fill       = r_fill;
        n_read_mode  = r_read_mode;
        n_xfer_len   = r_xfer_len;
        n_target_reg = r_target_reg;
        n_failed     = r_failed;
        buf_we       = 1'b0;
        n_scl        = 1'b1;
        n_sda        = 1'b1;
        n_rbyte      = 8'd0;
        n_rvalid     = 1'b0;
        n_rlast      = 1'b0;
        n_done       = 1'b0;
        n_stat       = 1'b0;

        case (r_phase)
            i2cm_pkg::PH_IDLE: begin
                if (i_command == i2cm_pkg::CMD_LOAD) begin
                    if (r_fill < LW'(i2cm_pkg::MAX_LEN)) begin
                        buf_we = 1'b1;
                        n_fill = r_fill + LW'(1);
                    end
                end else if (i_command == i2cm_pkg::CMD_WRITE ||
                             i_command == i2cm_pkg::CMD_READ) begin
                    // begin item runs the first start phase itself
                    n_read_mode  = (i_command == i2cm_pkg::CMD_READ);
                    if (i_command == i2cm_pkg::CMD_WRITE) begin
                        n_fill = '0;
                    end
                    n_xfer_len   = sat_len;
                    n_target_reg = i_register_address;
                    n_byte_cnt   = '0;
                    n_bit_cnt    = '0;
                    n_shift      = '0;
                    n_stage      = i2cm_pkg::STG_ADDR_W;
                    n_failed     = 1'b0;
                    n_phase      = i2cm_pkg::PH_ST_B;
                end
            end
            i2cm_pkg::PH_ST_A: begin
                n_phase = i2cm_pkg::PH_ST_B;
            end
            i2cm_pkg::PH_ST_B: begin
                n_sda   = 1'b0;
                n_phase = i2cm_pkg::PH_ST_C;
            end
            i2cm_pkg::PH_ST_C: begin
                n_scl     = 1'b0;
                n_sda     = 1'b0;
                n_shift   = {r_dev_addr, (r_stage == i2cm_pkg::STG_ADDR_R)};
                n_bit_cnt = '0;
                n_phase   = i2cm_pkg::PH_TX_LO;
            end
            i2cm_pkg::PH_TX_LO: begin
                n_scl   = 1'b0;
                n_sda   = r_shift[7];
                n_phase = i2cm_pkg::PH_TX_HI;
            end
            i2cm_pkg::PH_TX_HI: begin
                n_sda     = r_shift[7];
                n_shift   = {r_shift[6:0], 1'b0};
                n_bit_cnt = bit_inc;
                n_phase   = (bit_inc >= 4'd8) ? i2cm_pkg::PH_ACK_REL : i2cm_pkg::PH_TX_LO;
            end
            i2cm_pkg::PH_ACK_REL: begin
                n_scl     = 1'b0;
                n_ack_cnt = (r_ack_timeout != 8'd0) ? r_ack_timeout : 8'd1;
                n_phase   = i2cm_pkg::PH_ACK_POLL;
            end
            i2cm_pkg::PH_ACK_POLL: begin
                n_scl = 1'b0;
                if (!i_sda_in) begin
                    n_phase = i2cm_pkg::PH_ACK_CLK;
                end else begin
                    n_ack_cnt = ack_dec;
                    if (ack_dec == 8'd0) begin
                        n_failed = 1'b1;
                        n_phase  = i2cm_pkg::PH_SP_A;
                    end
                end
            end
            i2cm_pkg::PH_ACK_CLK: begin
                case (r_stage)
                    i2cm_pkg::STG_ADDR_W: begin
                        n_stage   = i2cm_pkg::STG_REG;
                        n_shift   = r_target_reg;
                        n_bit_cnt = '0;
                        n_phase   = i2cm_pkg::PH_TX_LO;
                    end
                    i2cm_pkg::STG_REG, i2cm_pkg::STG_DATA: begin
                        if (r_stage == i2cm_pkg::STG_REG && r_read_mode) begin
                            n_phase = i2cm_pkg::PH_RS_GAP;
                        end else begin
                            n_stage    = i2cm_pkg::STG_DATA;
                            n_byte_cnt = nd_cnt;
                            if (nd_avail) begin
                                n_shift   = r_wbuf[nd_cnt[i2cm_pkg::BUF_AW-1:0]];
                                n_bit_cnt = '0;
                                n_phase   = i2cm_pkg::PH_TX_LO;
                            end else begin
                                n_phase = i2cm_pkg::PH_SP_A;
                            end
                        end
                    end
                    i2cm_pkg::STG_ADDR_R: begin
                        n_byte_cnt = '0;
                        n_bit_cnt  = '0;
                        n_shift    = '0;
                        n_phase    = i2cm_pkg::PH_RX_LO;
                    end
                    default: begin
                        n_phase = i2cm_pkg::PH_SP_A;
                    end
                endcase
            end
            i2cm_pkg::PH_RS_GAP: begin
                n_scl   = 1'b0;
                n_stage = i2cm_pkg::STG_ADDR_R;
                n_phase = i2cm_pkg::PH_ST_A;
            end
            i2cm_pkg::PH_RX_LO: begin
                n_scl   = 1'b0;
                n_phase = i2cm_pkg::PH_RX_HI;
            end
            i2cm_pkg::PH_RX_HI: begin
                n_shift   = {r_shift[6:0], i_sda_in};
                n_bit_cnt = bit_inc;
                if (bit_inc >= 4'd8) begin
                    n_rbyte  = {r_shift[6:0], i_sda_in};
                    n_rvalid = 1'b1;
                    n_rlast  = last_byte;
                    n_phase  = i2cm_pkg::PH_MA_LO;
                end else begin
                    n_phase = i2cm_pkg::PH_RX_LO;
                end
            end
            i2cm_pkg::PH_MA_LO: begin
                n_scl   = 1'b0;
                n_sda   = last_byte;
                n_phase = i2cm_pkg::PH_MA_HI;
            end
            i2cm_pkg::PH_MA_HI: begin
                n_sda      = last_byte;
                n_byte_cnt = byte_inc[LW-1:0];
                if (last_byte) begin
                    n_phase = i2cm_pkg::PH_SP_A;
                end else begin
                    n_bit_cnt = '0;
                    n_shift   = '0;
                    n_phase   = i2cm_pkg::PH_RX_LO;
                end
            end
            i2cm_pkg::PH_SP_A: begin
                n_scl   = 1'b0;
                n_sda   = 1'b0;
                n_phase = i2cm_pkg::PH_SP_B;
            end
            i2cm_pkg::PH_SP_B: begin
                n_sda   = 1'b0;
                n_phase = i2cm_pkg::PH_SP_C;
            end
            i2cm_pkg::PH_SP_C: begin
                n_done   = 1'b1;
                n_stat   = r_failed;
                n_failed = 1'b0;
                n_phase  = i2cm_pkg::PH_IDLE;
            end
            default: begin
                n_phase = i2cm_pkg::PH_IDLE;
            end
        endcase
    end

    // controller state, advanced once per accepted item
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase      <= i2cm_pkg::PH_IDLE;
            r_stage      <= i2cm_pkg::STG_ADDR_W;
            r_bit_cnt    <= '0;
            r_byte_cnt   <= '0;
            r_shift      <= '0;
            r_ack_cnt    <= '0;
            r_fill       <= '0;
            r_read_mode  <= 1'b0;
            r_xfer_len   <= '0;
            r_target_reg <= '0;
            r_failed     <= 1'b0;
        end else if (accept) begin
            r_phase      <= n_phase;
            r_stage      <= n_stage;
            r_bit_cnt    <= n_bit_cnt;
            r_byte_cnt   <= n_byte_cnt;
            r_shift      <= n_shift;
            r_ack_cnt    <= n_ack_cnt;
            r_fill       <= n_fill;
            r_read_mode  <= n_read_mode;
            r_xfer_len   <= n_xfer_len;
            r_target_reg <= n_target_reg;
            r_failed     <= n_failed;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept && buf_we) begin
            r_wbuf[r_fill[i2cm_pkg::BUF_AW-1:0]] <= i_data_byte;
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_out_valid <= 1'b0;
        end else if (accept) begin
            o_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            o_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            o_scl_level  <= n_scl;
            o_sda_drive  <= n_sda;
            o_busy_res   <= (n_phase != i2cm_pkg::PH_IDLE);
            o_rx_byte    <= n_rbyte;
            o_read_valid <= n_rvalid;
            o_read_last  <= n_rlast;
            o_done_res   <= n_done;
            o_status     <= n_stat;
        end
    end

endmodule

`default_nettype wire

@@ rtl/core/i2cm_checker.sv @@
// Port-level checker for the I2C register master, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none

module i2cm_checker (
    input wire logic       i_clk,
    input wire logic       i_rst_n,
    input wire logic       o_out_valid,
    input wire logic       i_out_stall,
    input wire logic       o_scl_level,
    input wire logic       o_sda_drive,
    input wire logic       o_busy_res,
    input wire logic [7:0] o_rx_byte,
    input wire logic       o_read_valid,
    input wire logic       o_read_last,
    input wire logic       o_done_res,
    input wire logic       o_status
);

    // a stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_rx_byte)
            && $stable(o_scl_level) && $stable(o_done_res))
        else $error("result changed while stalled");

    a_last_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_read_last |-> o_read_valid)
        else $error("read_last without read_valid");

    a_status_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_status |-> o_done_res)
        else $error("status raised outside the stop phase");

    // the finishing phase is the stop edge: both lines high, bus free
    a_done_stop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_done_res |-> o_scl_level && o_sda_drive && !o_busy_res)
        else $error("done outside a stop condition");

    // a received byte completes on the clock-high phase of a busy transfer
    a_rx_phase: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_read_valid |-> o_scl_level && o_busy_res && !o_done_res)
        else $error("read byte outside a clock-high receive phase");

endmodule

bind i2c_register_master_top i2cm_checker u_i2cm_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .o_out_valid  (o_out_valid),
    .i_out_stall  (i_out_stall),
    .o_scl_level  (o_scl_level),
    .o_sda_drive  (o_sda_drive),
    .o_busy_res   (o_busy_res),
    .o_rx_byte    (o_rx_byte),
    .o_read_valid (o_read_valid),
    .o_read_last  (o_read_last),
    .o_done_res   (o_done_res),
    .o_status     (o_status)
);

`default_nettype wire
